// ===== rtl/byte_stack_with_edit_ops_unit_defines.svh =====
// assertion macros shared by the rtl
`ifndef BYTE_STACK_WITH_EDIT_OPS_UNIT_DEFINES_SVH
`define BYTE_STACK_WITH_EDIT_OPS_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSEO_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on clk, off during reset
`define BSEO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/bseo_pkg.sv =====
package bseo_pkg;

    localparam int DEPTH_DEF = 64;

    // payload widths, index and count sized from the default depth
    localparam int OPC_W   = 3;
    localparam int VAL_W   = 8;
    localparam int IDX_W   = $clog2(DEPTH_DEF);
    localparam int STAT_W  = 2;
    localparam int COUNT_W = $clog2(DEPTH_DEF + 1);

    typedef enum logic [OPC_W-1:0] {
        OPC_PUSH    = 3'd0,
        OPC_POP     = 3'd1,
        OPC_INSERT  = 3'd2,
        OPC_REVERSE = 3'd3,
        OPC_UPDATE  = 3'd4,
        OPC_CLEAR   = 3'd5
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // one datapath operation per cycle
    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_PUSH,
        DP_POP,
        DP_UPDATE,
        DP_CLEAR,
        DP_SRCH_START,
        DP_SRCH_STEP,
        DP_SHIFT_START,
        DP_SHIFT_STEP,
        DP_PLACE,
        DP_REV_START,
        DP_REV_RD,
        DP_REV_WLO,
        DP_REV_WHI,
        DP_FIN_RD
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    capture;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_ok;
        logic hit;
        logic last;
        logic shift_last;
        logic rev_any;
        logic rev_more;
    } dp_stat_t;

endpackage

// ===== rtl/bseo_in_if.sv =====
interface bseo_in_if import bseo_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] match_value;
    logic [IDX_W-1:0] index;

    modport source (
        output valid, opcode, value, match_value, index,
        input  ready
    );

    modport sink (
        input  valid, opcode, value, match_value, index,
        output ready
    );
endinterface

// ===== rtl/bseo_out_if.sv =====
interface bseo_out_if import bseo_pkg::*;;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
    logic [VAL_W-1:0]   top_value;
    logic [VAL_W-1:0]   bottom_value;
    logic               is_empty;

    modport source (
        output valid, status, count, top_value, bottom_value, is_empty,
        input  ready
    );

    modport sink (
        input  valid, status, count, top_value, bottom_value, is_empty,
        output ready
    );
endinterface

// ===== rtl/bseo_ram.sv =====
module bseo_ram import bseo_pkg::*;
#(
    parameter int WIDTH = VAL_W,
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/bseo_ctrl.sv =====
module bseo_ctrl import bseo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [OPC_W-1:0] opcode,
    output logic             out_valid,
    input  logic             out_ready,
    input  dp_stat_t         stat,
    output dp_cmd_t          cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH,
        S_SHIFT_START,
        S_SHIFT,
        S_PLACE,
        S_REV_RD,
        S_REV_WLO,
        S_REV_WHI,
        S_FIN,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [OPC_W-1:0] opcode_reg, opcode_next;
    status_t          status_reg, status_next;
    logic             out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        opcode_next    = opcode_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = DP_IDLE;
        cmd.capture    = 1'b0;
        cmd.status     = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op      = DP_LOAD;
                    opcode_next = opcode;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                state_next  = S_FIN;
                unique case (opcode_reg)
                    OPC_PUSH:
                    begin
                        if (stat.full)
                            status_next = ST_FULL;
                        else
                            cmd.op = DP_PUSH;
                    end
                    OPC_POP:
                    begin
                        if (stat.empty)
                            status_next = ST_EMPTY;
                        else
                            cmd.op = DP_POP;
                    end
                    OPC_INSERT:
                    begin
                        if (stat.empty)
                            status_next = ST_EMPTY;
                        else if (stat.full)
                            status_next = ST_FULL;
                        else
                        begin
                            cmd.op     = DP_SRCH_START;
                            state_next = S_SRCH;
                        end
                    end
                    OPC_REVERSE:
                    begin
                        if (stat.empty)
                            status_next = ST_EMPTY;
                        else
                        begin
                            cmd.op     = DP_REV_START;
                            state_next = S_REV_RD;
                        end
                    end
                    OPC_UPDATE:
                    begin
                        if (stat.idx_ok)
                            cmd.op = DP_UPDATE;
                        else
                            status_next = ST_NOTFOUND;
                    end
                    OPC_CLEAR:
                    begin
                        cmd.op = DP_CLEAR;
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_SRCH:
            begin
                cmd.op = DP_SRCH_STEP;
                if (stat.hit)
                    state_next = stat.last ? S_PLACE : S_SHIFT_START;
                else if (stat.last)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_FIN;
                end
            end
            S_SHIFT_START:
            begin
                cmd.op     = DP_SHIFT_START;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.op = DP_SHIFT_STEP;
                if (stat.shift_last)
                    state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.op     = DP_PLACE;
                state_next = S_FIN;
            end
            S_REV_RD:
            begin
                if (stat.rev_any)
                begin
                    cmd.op     = DP_REV_RD;
                    state_next = S_REV_WLO;
                end
                else
                    state_next = S_FIN;
            end
            S_REV_WLO:
            begin
                cmd.op     = DP_REV_WLO;
                state_next = S_REV_WHI;
            end
            S_REV_WHI:
            begin
                cmd.op     = DP_REV_WHI;
                state_next = stat.rev_more ? S_REV_WLO : S_FIN;
            end
            S_FIN:
            begin
                cmd.op     = DP_FIN_RD;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            opcode_reg    <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            opcode_reg    <= opcode_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/bseo_dp.sv =====
module bseo_dp import bseo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VAL_W-1:0]   value,
    input  logic [VAL_W-1:0]   match_value,
    input  logic [IDX_W-1:0]   index,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    output logic [STAT_W-1:0]  status,
    output logic [COUNT_W-1:0] count,
    output logic [VAL_W-1:0]   top_value,
    output logic [VAL_W-1:0]   bottom_value,
    output logic               is_empty
);

    localparam int AW    = $clog2(DEPTH);
    localparam int AW1   = AW + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [AW-1:0]      ptr_reg, ptr_next;   // search position, reverse low side
    logic [AW-1:0]      hi_reg, hi_next;     // shift target, reverse high side
    logic [VAL_W-1:0]   value_reg;
    logic [VAL_W-1:0]   match_reg;
    logic [IDX_W-1:0]   index_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic [VAL_W-1:0]   top_reg;
    logic [VAL_W-1:0]   bottom_reg;
    logic               empty_reg;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [VAL_W-1:0]   wdata;
    logic               re_a, re_b;
    logic [AW-1:0]      raddr_a, raddr_b;
    logic [VAL_W-1:0]   rdata_a, rdata_b;
    logic [AW-1:0]      count_m1;

    assign count_m1 = AW'(count_reg - CNT_W'(1));

    assign stat.full       = (count_reg == CNT_W'(DEPTH));
    assign stat.empty      = (count_reg == '0);
    assign stat.idx_ok     = (CMP_W'(index_reg) < CMP_W'(count_reg));
    assign stat.hit        = (rdata_a == match_reg);
    assign stat.last       = (ptr_reg == count_m1);
    assign stat.shift_last = (AW1'(hi_reg) == AW1'(ptr_reg) + AW1'(2));
    assign stat.rev_any    = (ptr_reg < hi_reg);
    assign stat.rev_more   = (AW1'(ptr_reg) + AW1'(2) < AW1'(hi_reg));

    always_comb
    begin
        we         = 1'b0;
        waddr      = AW'(count_reg);
        wdata      = value_reg;
        re_a       = 1'b0;
        raddr_a    = ptr_reg;
        re_b       = 1'b0;
        raddr_b    = hi_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        hi_next    = hi_reg;

        unique case (cmd.op)
            DP_IDLE, DP_LOAD:
            begin
            end
            DP_PUSH:
            begin
                we         = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            DP_POP:
            begin
                count_next = count_reg - CNT_W'(1);
            end
            DP_UPDATE:
            begin
                we    = 1'b1;
                waddr = AW'(index_reg);
            end
            DP_CLEAR:
            begin
                count_next = '0;
            end
            DP_SRCH_START:
            begin
                re_a     = 1'b1;
                raddr_a  = '0;
                ptr_next = '0;
            end
            DP_SRCH_STEP:
            begin
                // hold the position on a hit, otherwise stream the next entry
                if (!stat.hit)
                begin
                    re_a     = 1'b1;
                    raddr_a  = ptr_reg + AW'(1);
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            DP_SHIFT_START:
            begin
                hi_next = AW'(count_reg);
                re_a    = 1'b1;
                raddr_a = count_m1;
            end
            DP_SHIFT_STEP:
            begin
                we      = 1'b1;
                waddr   = hi_reg;
                wdata   = rdata_a;
                hi_next = hi_reg - AW'(1);
                re_a    = 1'b1;
                raddr_a = hi_reg - AW'(2);
            end
            DP_PLACE:
            begin
                we         = 1'b1;
                waddr      = ptr_reg + AW'(1);
                count_next = count_reg + CNT_W'(1);
            end
            DP_REV_START:
            begin
                ptr_next = '0;
                hi_next  = count_m1;
            end
            DP_REV_RD:
            begin
                re_a = 1'b1;
                re_b = 1'b1;
            end
            DP_REV_WLO:
            begin
                we    = 1'b1;
                waddr = ptr_reg;
                wdata = rdata_b;
            end
            DP_REV_WHI:
            begin
                we       = 1'b1;
                waddr    = hi_reg;
                wdata    = rdata_a;
                ptr_next = ptr_reg + AW'(1);
                hi_next  = hi_reg - AW'(1);
                re_a     = 1'b1;
                raddr_a  = ptr_reg + AW'(1);
                re_b     = 1'b1;
                raddr_b  = hi_reg - AW'(1);
            end
            DP_FIN_RD:
            begin
                re_a    = 1'b1;
                raddr_a = count_m1;
                re_b    = 1'b1;
                raddr_b = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            hi_reg    <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LOAD)
        begin
            value_reg <= value;
            match_reg <= match_value;
            index_reg <= index;
        end
        if (cmd.capture)
        begin
            status_reg    <= cmd.status;
            count_out_reg <= COUNT_W'(count_reg);
            top_reg       <= stat.empty ? '0 : rdata_a;
            bottom_reg    <= stat.empty ? '0 : rdata_b;
            empty_reg     <= stat.empty;
        end
    end

    assign status       = status_reg;
    assign count        = count_out_reg;
    assign top_value    = top_reg;
    assign bottom_value = bottom_reg;
    assign is_empty     = empty_reg;

    bseo_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re_a    (re_a),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .re_b    (re_b),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

endmodule

// ===== rtl/byte_stack_with_edit_ops_unit.sv =====
// push, pop, update, clear and every error but a failed insert search: exec, fin, done, then result valid
// insert after match: one entry per cycle searched, then shifted, then the new entry placed
// reverse: each swapped pair takes a low write and a high write on the single ram write port
// one transaction in flight; the next is taken while the previous result waits in the output reg
// async active-low reset empties the stack and drops any pending result; ram contents not cleared
`include "byte_stack_with_edit_ops_unit_defines.svh"

module byte_stack_with_edit_ops_unit import bseo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    bseo_in_if.sink           item,
    bseo_out_if.source        result
);

    // command and status between the sequencer and the stack datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller: accepts one transaction, walks the datapath through the
    // operation, then parks the result in the output register
    bseo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .opcode    (item.opcode),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: fill count, walk pointers, entry ram and result register
    bseo_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (item.value),
        .match_value  (item.match_value),
        .index        (item.index),
        .cmd          (cmd),
        .stat         (stat),
        .status       (result.status),
        .count        (result.count),
        .top_value    (result.top_value),
        .bottom_value (result.bottom_value),
        .is_empty     (result.is_empty)
    );

    // never grow the stack past its depth
    `BSEO_ASSERT_IMPL(a_no_grow_when_full, cmd.op == DP_PUSH || cmd.op == DP_PLACE, !stat.full)
    // an empty result reports zero size and zero values
    `BSEO_ASSERT_IMPL(a_empty_result, result.valid && result.is_empty,
        result.count == '0 && result.top_value == '0 && result.bottom_value == '0)
    // a full status comes only with a full stack
    `BSEO_ASSERT_IMPL(a_full_status, result.valid && result.status == ST_FULL,
        result.count == COUNT_W'(DEPTH))
    // one transaction at a time
    `BSEO_ASSERT_NEXT(a_single_item, item.valid && item.ready, !item.ready)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb import bseo_pkg::*;;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int RANDOM_OPS = 1300;
    // cycles to watch for stray results after the last expected one
    localparam int TAIL_CYCLES = 150;

    // opcodes the block decodes as no-ops, still answered with one result
    localparam logic [OPC_W-1:0] OPC_SPARE_LO = 3'd6;
    localparam logic [OPC_W-1:0] OPC_SPARE_HI = 3'd7;

    // what a result transaction should carry
    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic [VAL_W-1:0]   top_value;
        logic [VAL_W-1:0]   bottom_value;
        logic               is_empty;
    } stack_report_t;

    // biases for the random stimulus: fill up, drain, or a bit of both
    typedef enum {PH_GROW, PH_SHRINK, PH_MIX} phase_kind_t;

    // mirror of the stack contents plus the queue of reports still owed by the dut
    class stack_mirror;
        logic [VAL_W-1:0] entries [STACK_DEPTH];
        int unsigned      fill;
        stack_report_t    pending_reports [$];
        int unsigned      errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        // apply one accepted operation and queue the report it must produce
        function void note_op(input logic [OPC_W-1:0] opcode, input logic [VAL_W-1:0] value,
                              input logic [VAL_W-1:0] match_value,
                              input logic [IDX_W-1:0] index);
            status_t          st;
            int unsigned      pos;
            int unsigned      k;
            int unsigned      lo;
            int unsigned      hi;
            bit               hit;
            logic [VAL_W-1:0] swap;
            stack_report_t    rep;
            st = ST_OK;
            case (opcode)
                OPC_PUSH:
                begin
                    if (fill >= STACK_DEPTH)
                        st = ST_FULL;
                    else
                    begin
                        entries[fill] = value;
                        fill++;
                    end
                end
                OPC_POP:
                begin
                    if (fill == 0)
                        st = ST_EMPTY;
                    else
                        fill--;
                end
                OPC_INSERT:
                begin
                    // empty and full are decided before any search
                    if (fill == 0)
                        st = ST_EMPTY;
                    else if (fill >= STACK_DEPTH)
                        st = ST_FULL;
                    else
                    begin
                        hit = 1'b0;
                        pos = 0;
                        while (!hit && pos < fill)
                        begin
                            if (entries[pos] == match_value)
                                hit = 1'b1;
                            else
                                pos++;
                        end
                        if (!hit)
                            st = ST_NOTFOUND;
                        else
                        begin
                            for (k = fill; k > pos + 1; k--)
                                entries[k] = entries[k - 1];
                            entries[pos + 1] = value;
                            fill++;
                        end
                    end
                end
                OPC_REVERSE:
                begin
                    if (fill == 0)
                        st = ST_EMPTY;
                    else
                    begin
                        lo = 0;
                        hi = fill - 1;
                        while (lo < hi)
                        begin
                            swap = entries[lo];
                            entries[lo] = entries[hi];
                            entries[hi] = swap;
                            lo++;
                            hi--;
                        end
                    end
                end
                OPC_UPDATE:
                begin
                    if (index >= fill)
                        st = ST_NOTFOUND;
                    else
                        entries[index] = value;
                end
                OPC_CLEAR:
                    fill = 0;
                default:
                    st = ST_OK;
            endcase
            rep.status = st;
            rep.count = fill[COUNT_W-1:0];
            rep.is_empty = (fill == 0);
            rep.top_value = (fill == 0) ? '0 : entries[fill - 1];
            rep.bottom_value = (fill == 0) ? '0 : entries[0];
            pending_reports.push_back(rep);
        endfunction

        function void check_result(input stack_report_t got);
            stack_report_t want;
            if (pending_reports.size() == 0)
            begin
                $error("result transaction with no operation outstanding");
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, actual %0d", want.count, got.count);
                errors++;
            end
            if (got.top_value !== want.top_value)
            begin
                $error("top_value: expected %0d, actual %0d", want.top_value, got.top_value);
                errors++;
            end
            if (got.bottom_value !== want.bottom_value)
            begin
                $error("bottom_value: expected %0d, actual %0d",
                       want.bottom_value, got.bottom_value);
                errors++;
            end
            if (got.is_empty !== want.is_empty)
            begin
                $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_reports.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bseo_in_if  item_if ();
    bseo_out_if result_if ();

    byte_stack_with_edit_ops_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    stack_mirror mirror = new();

    // when set, that side runs back to back with no idle cycles
    bit          send_burst;
    bit          recv_burst;
    int unsigned sent_ops;
    int unsigned cycle_count;

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // every dut input known from time zero, reset held low at start, then released
    initial
    begin
        rst_n <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.opcode <= '0;
        item_if.value <= '0;
        item_if.match_value <= '0;
        item_if.index <= '0;
        result_if.ready <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // one input transaction: optional idle gap, then hold valid until accepted
    // valid stays high on return so a zero gap next time needs no extra assignment
    task automatic send_op(input logic [OPC_W-1:0] opcode, input logic [VAL_W-1:0] value,
                           input logic [VAL_W-1:0] match_value,
                           input logic [IDX_W-1:0] index);
        int unsigned gap;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.opcode <= opcode;
        item_if.value <= value;
        item_if.match_value <= match_value;
        item_if.index <= index;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        mirror.note_op(opcode, value, match_value, index);
        sent_ops++;
    endtask

    // stop sending until the dut has answered everything it took
    // always advances the clock before checking, so valid is never dropped and raised in one step
    task automatic drain();
        item_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (mirror.outstanding() != 0);
    endtask

    // small value pool half the time so matches and duplicates are common
    function automatic logic [VAL_W-1:0] pick_byte();
        if ($urandom_range(0, 1) == 0)
            return VAL_W'($urandom_range(0, 15));
        return VAL_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [OPC_W-1:0] pick_op(input phase_kind_t kind);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (kind)
            PH_GROW:
            begin
                if (roll < 45) return OPC_PUSH;
                if (roll < 80) return OPC_INSERT;
                if (roll < 88) return OPC_UPDATE;
                if (roll < 94) return OPC_REVERSE;
                if (roll < 98) return OPC_POP;
            end
            PH_SHRINK:
            begin
                if (roll < 55) return OPC_POP;
                if (roll < 67) return OPC_PUSH;
                if (roll < 77) return OPC_INSERT;
                if (roll < 87) return OPC_UPDATE;
                if (roll < 95) return OPC_REVERSE;
                if (roll < 97) return OPC_CLEAR;
            end
            default:
            begin
                if (roll < 28) return OPC_PUSH;
                if (roll < 50) return OPC_POP;
                if (roll < 68) return OPC_INSERT;
                if (roll < 80) return OPC_UPDATE;
                if (roll < 92) return OPC_REVERSE;
                if (roll < 96) return OPC_CLEAR;
            end
        endcase
        return ($urandom_range(0, 1) == 0) ? OPC_SPARE_LO : OPC_SPARE_HI;
    endfunction

    // random operation; match and index mostly aimed at live entries
    task automatic send_random_op(input phase_kind_t kind);
        logic [OPC_W-1:0] opcode;
        logic [VAL_W-1:0] match_value;
        logic [IDX_W-1:0] index;
        opcode = pick_op(kind);
        if (mirror.fill != 0 && $urandom_range(0, 4) != 0)
            match_value = mirror.entries[$urandom_range(0, mirror.fill - 1)];
        else
            match_value = VAL_W'($urandom_range(0, 255));
        if (mirror.fill != 0 && $urandom_range(0, 4) != 0)
            index = IDX_W'($urandom_range(0, mirror.fill - 1));
        else
            index = IDX_W'($urandom_range(0, 63));
        send_op(opcode, pick_byte(), match_value, index);
    endtask

    // result side: random stall before each transaction, with burst stretches
    initial
    begin
        int unsigned   stall;
        stack_report_t got;
        recv_burst = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = recv_burst ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_if.valid === 1'b1 && result_if.ready === 1'b1));
            got.status = status_t'(result_if.status);
            got.count = result_if.count;
            got.top_value = result_if.top_value;
            got.bottom_value = result_if.bottom_value;
            got.is_empty = result_if.is_empty;
            mirror.check_result(got);
            if ($urandom_range(0, 49) == 0)
                recv_burst = !recv_burst;
        end
    end

    // main stimulus
    initial
    begin
        phase_kind_t kind;
        int unsigned len;
        bit          first_phase;
        send_burst = 1'b0;
        sent_ops = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // directed: every error on an empty stack, spare opcodes, byte extremes
        send_op(OPC_POP, 8'h00, 8'h00, 6'd0);
        send_op(OPC_REVERSE, 8'hff, 8'hff, 6'd63);
        send_op(OPC_INSERT, 8'h12, 8'h00, 6'd0);
        send_op(OPC_UPDATE, 8'h34, 8'h00, 6'd0);
        send_op(OPC_CLEAR, 8'h00, 8'h00, 6'd0);
        send_op(OPC_SPARE_LO, 8'h00, 8'h00, 6'd0);
        send_op(OPC_SPARE_HI, 8'hff, 8'hff, 6'd63);
        send_op(OPC_PUSH, 8'h00, 8'hff, 6'd63);
        send_op(OPC_PUSH, 8'hff, 8'h00, 6'd0);
        send_op(OPC_PUSH, 8'h5a, 8'h00, 6'd0);
        // three entries flipped, 0x5a now at the bottom
        send_op(OPC_REVERSE, 8'h00, 8'h00, 6'd0);
        // match on the bottom entry, higher entries move up
        send_op(OPC_INSERT, 8'ha5, 8'h5a, 6'd0);
        // no entry holds the match byte
        send_op(OPC_INSERT, 8'h77, 8'h11, 6'd0);
        // match on the top entry, lands above everything
        send_op(OPC_INSERT, 8'h3c, 8'h00, 6'd0);
        send_op(OPC_UPDATE, 8'hff, 8'h00, 6'd0);
        send_op(OPC_UPDATE, 8'h99, 8'h00, 6'd63);
        send_op(OPC_UPDATE, 8'h80, 8'h00, 6'd4);
        send_op(OPC_UPDATE, 8'h81, 8'h00, 6'd5);
        send_op(OPC_POP, 8'h00, 8'h00, 6'd0);
        send_op(OPC_CLEAR, 8'hff, 8'hff, 6'd63);
        send_op(OPC_POP, 8'h00, 8'h00, 6'd0);
        send_op(OPC_PUSH, 8'h01, 8'h00, 6'd0);
        // single entry reverse, then clear of a one-deep stack
        send_op(OPC_REVERSE, 8'h00, 8'h00, 6'd0);
        send_op(OPC_CLEAR, 8'h00, 8'h00, 6'd0);

        // random phases; the first one fills the stack past full
        // the sender waits for all results before the first phase and at random later
        sent_ops = 0;
        first_phase = 1'b1;
        while (sent_ops < RANDOM_OPS)
        begin
            if (first_phase)
            begin
                kind = PH_GROW;
                len = 130;
            end
            else
            begin
                kind = phase_kind_t'($urandom_range(0, 2));
                len = $urandom_range(20, 120);
            end
            if (first_phase || $urandom_range(0, 2) == 0)
                drain();
            first_phase = 1'b0;
            send_burst = ($urandom_range(0, 3) == 0);
            repeat (len)
                send_random_op(kind);
        end

        // all transactions in: wait for the last results, then watch for strays
        send_burst = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mirror.errors == 0 && mirror.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
